// ===== src/nbga_pkg.sv =====
// shared types and constants for the n-body gravity acceleration block
// no dependencies
`default_nettype none

package nbga_pkg;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [1:0] AXIS_X    = 2'd0;
  localparam logic [1:0] AXIS_Y    = 2'd1;
  localparam logic [1:0] AXIS_Z    = 2'd2;
  localparam logic [1:0] AXIS_NONE = 2'd3;

  localparam logic [4:0]  BODY_COUNT_RST = 5'd10;
  // 4 pi^2 in q.32
  localparam logic [37:0] G_Q32          = 38'd169558512509;
  localparam logic [99:0] MUL_SAT_LIM    = 100'd1 << 81;
  localparam logic [67:0] TERM_LIM       = 68'd1 << 48;
  localparam logic [48:0] TERM_CAP       = 49'd1 << 48;
  localparam logic signed [53:0] ACC_MAX = 54'sd140737488355327;
  localparam logic signed [53:0] ACC_MIN = -54'sd140737488355328;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RD0,
    S_RDI,
    S_PI,
    S_JSEL,
    S_JDAT,
    S_SQ,
    S_SQADD,
    S_CHK,
    S_SQRT,
    S_D1SET,
    S_DIV1,
    S_D2SET,
    S_DIV2,
    S_GMSET,
    S_GM,
    S_DKSET,
    S_DIVK,
    S_KQSET,
    S_KQ,
    S_TERM,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== src/nbga_if.sv =====
// item and result channels of the n-body gravity acceleration block
// no dependencies
`default_nettype none

interface nbga_item_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [3:0]  body_index;
  logic [1:0]  axis;
  logic [47:0] mass;
  logic signed [47:0] pos_x;
  logic signed [47:0] pos_y;
  logic signed [47:0] pos_z;

  modport source (output valid, kind, body_index, axis, mass, pos_x, pos_y, pos_z,
                  input ready);
  modport sink (input valid, kind, body_index, axis, mass, pos_x, pos_y, pos_z,
                output ready);
endinterface

interface nbga_result_if;
  logic        valid;
  logic        ready;
  logic signed [47:0] acceleration;
  logic        overflow;

  modport source (output valid, acceleration, overflow, input ready);
  modport sink (input valid, acceleration, overflow, output ready);
endinterface

`default_nettype wire

// ===== src/nbody_gravity_acceleration.sv =====
// direct-sum gravitational acceleration over a table of bodies
// depends on nbga_pkg and the channel interfaces in nbga_if.sv
// load beat: written to the table on acceptance, block stays ready
// query beat: result valid once the sequencer has run over every other active body;
// a pair is skipped early at zero distance or zero reference mass; the work is done
// by one shared shift-add/subtract unit
// that runs squares, square root, three divisions and two products bit by bit
// ready only while idle; a finished result waits in the output register
// reset clears control state and sets body_count to 10; body table is not cleared
`default_nettype none

module nbody_gravity_acceleration
  import nbga_pkg::*;
#(
  parameter int MAX_BODIES = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic [4:0] cfg_data,
  nbga_item_if.sink       item,
  nbga_result_if.source   result
);

  localparam int AW = (MAX_BODIES > 2) ? $clog2(MAX_BODIES) : 1;
  localparam int CW = $clog2(MAX_BODIES + 1);

  state_t state, state_next;

  logic [4:0] body_count;

  logic [47:0] mem_mass  [MAX_BODIES];
  logic [47:0] mem_pos_x [MAX_BODIES];
  logic [47:0] mem_pos_y [MAX_BODIES];
  logic [47:0] mem_pos_z [MAX_BODIES];
  logic [47:0] rd_mass, rd_pos_x, rd_pos_y, rd_pos_z;
  logic [AW-1:0] rd_addr;
  logic load_we, query_go, done_fire;

  logic [3:0]  q_idx;
  logic [1:0]  q_axis;
  logic [47:0] m0, mj;
  logic [47:0] pi_x, pi_y, pi_z;
  logic [47:0] ax_r, ay_r, az_r, ad;
  logic        neg;
  logic [CW-1:0] j, active;
  logic [97:0] s;
  logic [96:0] q2;
  logic [1:0]  sq_sel;
  logic signed [53:0] sum;
  logic        flag;

  logic [127:0] u_num;
  logic [98:0]  u_rem;
  logic [96:0]  u_quo;
  logic [97:0]  u_den;
  logic [85:0]  u_a;
  logic [96:0]  u_b;
  logic [99:0]  u_acc;
  logic         u_hit;
  logic [6:0]   u_cnt;

  logic        res_valid;
  logic signed [47:0] res_acc;
  logic        res_ovf;

  // shared unit step
  logic [99:0] mul_raw, mul_next;
  logic        mul_hit;
  logic [98:0] div_sh, div_rem_next;
  logic        div_ge;
  logic [98:0] sq_sh, sq_trial, sq_rem_next;
  logic        sq_ge;

  always_comb begin
    mul_raw  = {u_acc[98:0], 1'b0} + (u_b[96] ? {14'd0, u_a} : 100'd0);
    mul_hit  = (state == S_KQ) && (mul_raw >= MUL_SAT_LIM);
    mul_next = mul_hit ? MUL_SAT_LIM : mul_raw;
    div_sh   = {u_rem[97:0], u_num[127]};
    div_ge   = div_sh >= {1'b0, u_den};
    div_rem_next = div_ge ? div_sh - {1'b0, u_den} : div_sh;
    sq_sh    = {u_rem[96:0], u_num[127:126]};
    sq_trial = {u_quo, 2'b01};
    sq_ge    = sq_sh >= sq_trial;
    sq_rem_next = sq_ge ? sq_sh - sq_trial : sq_sh;
  end

  // body differences
  logic signed [48:0] dx, dy, dz;
  logic [47:0] ax, ay, az;
  logic [48:0] term;
  logic        term_cap;

  always_comb begin
    dx = {rd_pos_x[47], rd_pos_x} - {pi_x[47], pi_x};
    dy = {rd_pos_y[47], rd_pos_y} - {pi_y[47], pi_y};
    dz = {rd_pos_z[47], rd_pos_z} - {pi_z[47], pi_z};
    ax = dx[48] ? 48'(-dx) : dx[47:0];
    ay = dy[48] ? 48'(-dy) : dy[47:0];
    az = dz[48] ? 48'(-dz) : dz[47:0];
    term_cap = u_hit || (u_acc[99:32] > TERM_LIM);
    term     = term_cap ? TERM_CAP : u_acc[80:32];
  end

  always_comb begin
    active = (32'(body_count) >= MAX_BODIES) ? CW'(MAX_BODIES) : CW'(body_count);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (query_go) begin
          if (item.axis == AXIS_NONE || 32'(item.body_index) >= MAX_BODIES) begin
            state_next = S_DONE;
          end else begin
            state_next = S_RD0;
          end
        end
      end
      S_RD0:   state_next = S_RDI;
      S_RDI:   state_next = S_PI;
      S_PI:    state_next = S_JSEL;
      S_JSEL: begin
        if (j >= active) begin
          state_next = S_DONE;
        end else if (32'(j) != 32'(q_idx)) begin
          state_next = S_JDAT;
        end
      end
      S_JDAT:  state_next = S_SQ;
      S_SQ:    state_next = (u_cnt == 7'd1) ? S_SQADD : S_SQ;
      S_SQADD: state_next = (sq_sel == 2'd2) ? S_CHK : S_SQ;
      S_CHK:   state_next = (s == '0 || m0 == '0) ? S_JSEL : S_SQRT;
      S_SQRT:  state_next = (u_cnt == 7'd1) ? S_D1SET : S_SQRT;
      S_D1SET: state_next = S_DIV1;
      S_DIV1:  state_next = (u_cnt == 7'd1) ? S_D2SET : S_DIV1;
      S_D2SET: state_next = S_DIV2;
      S_DIV2:  state_next = (u_cnt == 7'd1) ? S_GMSET : S_DIV2;
      S_GMSET: state_next = S_GM;
      S_GM:    state_next = (u_cnt == 7'd1) ? S_DKSET : S_GM;
      S_DKSET: state_next = S_DIVK;
      S_DIVK:  state_next = (u_cnt == 7'd1) ? S_KQSET : S_DIVK;
      S_KQSET: state_next = S_KQ;
      S_KQ:    state_next = (u_cnt == 7'd1) ? S_TERM : S_KQ;
      S_TERM:  state_next = S_JSEL;
      S_DONE:  state_next = done_fire ? S_IDLE : S_DONE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    item.ready = (state == S_IDLE);
    query_go   = item.valid && item.ready && (item.kind == KIND_QUERY);
    load_we    = item.valid && item.ready && (item.kind == KIND_LOAD) &&
                 (32'(item.body_index) < MAX_BODIES);
    done_fire  = (state == S_DONE) && (!res_valid || result.ready);
    case (state)
      S_RDI:   rd_addr = AW'(q_idx);
      S_JSEL:  rd_addr = AW'(j);
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      body_count <= BODY_COUNT_RST;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        body_count <= cfg_data;
      end
    end
  end

  // body table
  always_ff @(posedge clk) begin
    if (load_we) begin
      mem_mass[AW'(item.body_index)]  <= item.mass;
      mem_pos_x[AW'(item.body_index)] <= item.pos_x;
      mem_pos_y[AW'(item.body_index)] <= item.pos_y;
      mem_pos_z[AW'(item.body_index)] <= item.pos_z;
    end
    rd_mass  <= mem_mass[rd_addr];
    rd_pos_x <= mem_pos_x[rd_addr];
    rd_pos_y <= mem_pos_y[rd_addr];
    rd_pos_z <= mem_pos_z[rd_addr];
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        q_idx  <= item.body_index;
        q_axis <= item.axis;
        sum    <= '0;
        flag   <= 1'b0;
      end
      S_RDI: m0 <= rd_mass;
      S_PI: begin
        pi_x <= rd_pos_x;
        pi_y <= rd_pos_y;
        pi_z <= rd_pos_z;
        j    <= '0;
      end
      S_JSEL: begin
        if (j < active && 32'(j) == 32'(q_idx)) begin
          j <= j + CW'(1);
        end
      end
      S_JDAT: begin
        ax_r <= ax;
        ay_r <= ay;
        az_r <= az;
        mj   <= rd_mass;
        case (q_axis)
          AXIS_X: begin
            ad  <= ax;
            neg <= dx[48];
          end
          AXIS_Y: begin
            ad  <= ay;
            neg <= dy[48];
          end
          default: begin
            ad  <= az;
            neg <= dz[48];
          end
        endcase
        s      <= '0;
        sq_sel <= 2'd0;
        u_acc  <= '0;
        u_a    <= {38'd0, ax};
        u_b    <= {ax, 49'd0};
        u_cnt  <= 7'd48;
      end
      S_SQ, S_GM, S_KQ: begin
        u_acc <= mul_next;
        u_b   <= {u_b[95:0], 1'b0};
        u_hit <= u_hit | mul_hit;
        u_cnt <= u_cnt - 7'd1;
      end
      S_SQADD: begin
        s      <= s + u_acc[97:0];
        sq_sel <= sq_sel + 2'd1;
        u_acc  <= '0;
        u_cnt  <= 7'd48;
        if (sq_sel == 2'd0) begin
          u_a <= {38'd0, ay_r};
          u_b <= {ay_r, 49'd0};
        end else begin
          u_a <= {38'd0, az_r};
          u_b <= {az_r, 49'd0};
        end
      end
      S_CHK: begin
        if (s == '0 || m0 == '0) begin
          flag <= 1'b1;
          j    <= j + CW'(1);
        end
        u_num <= {2'b00, s, 28'd0};
        u_rem <= '0;
        u_quo <= '0;
        u_cnt <= 7'd50;
      end
      S_SQRT: begin
        u_rem <= sq_rem_next;
        u_quo <= {u_quo[95:0], sq_ge};
        u_num <= {u_num[125:0], 2'b00};
        u_cnt <= u_cnt - 7'd1;
      end
      S_DIV1, S_DIV2, S_DIVK: begin
        u_rem <= div_rem_next;
        u_quo <= {u_quo[95:0], div_ge};
        u_num <= {u_num[126:0], 1'b0};
        u_cnt <= u_cnt - 7'd1;
      end
      S_D1SET: begin
        u_num <= {ad, 80'd0};
        u_den <= {48'd0, u_quo[49:0]};
        u_rem <= '0;
        u_quo <= '0;
        u_cnt <= 7'd80;
      end
      S_D2SET: begin
        u_num <= {u_quo[32:0], 95'd0};
        u_den <= s;
        u_rem <= '0;
        u_quo <= '0;
        u_cnt <= 7'd97;
      end
      S_GMSET: begin
        q2    <= u_quo;
        u_acc <= '0;
        u_a   <= {38'd0, mj};
        u_b   <= {G_Q32, 59'd0};
        u_cnt <= 7'd38;
      end
      S_DKSET: begin
        u_num <= {u_acc[85:0], 42'd0};
        u_den <= {50'd0, m0};
        u_rem <= '0;
        u_quo <= '0;
        u_cnt <= 7'd86;
      end
      S_KQSET: begin
        u_a   <= u_quo[85:0];
        u_b   <= q2;
        u_acc <= '0;
        u_hit <= 1'b0;
        u_cnt <= 7'd97;
      end
      S_TERM: begin
        if (term_cap) begin
          flag <= 1'b1;
        end
        if (neg) begin
          sum <= sum - $signed({5'd0, term});
        end else begin
          sum <= sum + $signed({5'd0, term});
        end
        j <= j + CW'(1);
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      if (result.ready) begin
        res_valid <= 1'b0;
      end
      if (done_fire) begin
        res_valid <= 1'b1;
      end
    end
    if (done_fire) begin
      if (sum > ACC_MAX) begin
        res_acc <= ACC_MAX[47:0];
        res_ovf <= 1'b1;
      end else if (sum < ACC_MIN) begin
        res_acc <= ACC_MIN[47:0];
        res_ovf <= 1'b1;
      end else begin
        res_acc <= sum[47:0];
        res_ovf <= flag;
      end
    end
  end

  assign result.valid        = res_valid;
  assign result.acceleration = res_acc;
  assign result.overflow     = res_ovf;

  a_query_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    query_go |=> state != S_IDLE)
    else $error("query beat did not start the sequencer");

  a_load_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready && item.kind == KIND_LOAD) |=> state == S_IDLE)
    else $error("load beat left idle");

  a_sqrt_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQRT || state == S_DIV1 || state == S_DIV2 || state == S_KQ)
      |-> u_cnt != 7'd0)
    else $error("shared unit ran with an empty step count");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == S_DONE)
    else $error("result raised outside the done state");

endmodule

`default_nettype wire

// ===== test/nbody_gravity_acceleration_test.sv =====
// self-checking testbench for nbody_gravity_acceleration: loads bodies, queries
// accelerations and compares every result beat with a local fixed-point predictor
// depends on nbga_pkg, nbga_if.sv and the block itself
`default_nettype none

module nbody_gravity_acceleration_test
  import nbga_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBODIES = 16;
  localparam longint CYCLE_LIMIT = 20000000;

  typedef struct packed {
    logic        kind;
    logic [3:0]  body_index;
    logic [1:0]  axis;
    logic [47:0] mass;
    logic [47:0] pos_x;
    logic [47:0] pos_y;
    logic [47:0] pos_z;
  } beat_t;

  typedef struct packed {
    logic [47:0] acceleration;
    logic        overflow;
  } accel_t;

  logic       clk;
  logic       rst;
  logic       cfg_write;
  logic [4:0] cfg_data;

  nbga_item_if   item_ch ();
  nbga_result_if res_ch ();

  nbody_gravity_acceleration DUT (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .item(item_ch.sink), .result(res_ch.source)
  );

  beat_t  pending_beats[$];
  accel_t expected_accels[$];
  logic [47:0] tbl_mass[NBODIES];
  logic [47:0] tbl_x[NBODIES];
  logic [47:0] tbl_y[NBODIES];
  logic [47:0] tbl_z[NBODIES];
  logic [4:0]  active_count;
  int  fails, n_loads, n_queries, n_checked, n_settings, n_items, n_ovf;
  bit  no_idle;
  int  send_gap, stall_len;
  longint cycles;

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (no_idle || p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [63:0] isqrt(logic [127:0] s);
    logic [63:0]  r, t;
    logic [127:0] sq;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      t = r | (64'd1 << b);
      sq = {64'd0, t} * {64'd0, t};
      if (sq <= s) r = t;
    end
    return r;
  endfunction

  function automatic logic [48:0] term_size(logic [48:0] ad, logic [127:0] s,
                                            logic [47:0] mj, logic [47:0] m0,
                                            inout bit ovf);
    logic [127:0] r, num, q1, q2, k;
    logic [255:0] pp;
    r = {64'd0, isqrt(s)};
    num = {79'd0, ad} << 32;
    q1 = num / r;
    q2 = {q1[63:0], 64'd0} / s;
    k = ({90'd0, G_Q32} * {80'd0, mj}) / {80'd0, m0};
    pp = {128'd0, k} * {128'd0, q2};
    pp = pp >> 32;
    if (pp > 256'(TERM_CAP)) begin
      ovf = 1'b1;
      return TERM_CAP;
    end
    return pp[48:0];
  endfunction

  function automatic accel_t predict_accel(logic [3:0] idx, logic [1:0] axis);
    accel_t res;
    logic signed [48:0] d[3];
    logic [48:0]  a[3];
    logic [127:0] s;
    logic [48:0]  t;
    logic signed [63:0] acc;
    int  n;
    bit  ovf;
    res = '0;
    if (axis == AXIS_NONE) return res;
    n = active_count > NBODIES ? NBODIES : active_count;
    acc = 0;
    ovf = 1'b0;
    for (int j = 0; j < n; j++) begin
      if (j == idx) continue;
      d[0] = $signed({tbl_x[j][47], tbl_x[j]}) - $signed({tbl_x[idx][47], tbl_x[idx]});
      d[1] = $signed({tbl_y[j][47], tbl_y[j]}) - $signed({tbl_y[idx][47], tbl_y[idx]});
      d[2] = $signed({tbl_z[j][47], tbl_z[j]}) - $signed({tbl_z[idx][47], tbl_z[idx]});
      for (int c = 0; c < 3; c++) a[c] = d[c] < 0 ? -d[c] : d[c];
      s = {79'd0, a[0]} * {79'd0, a[0]} + {79'd0, a[1]} * {79'd0, a[1]}
        + {79'd0, a[2]} * {79'd0, a[2]};
      if (s == 0 || tbl_mass[0] == 0) begin
        ovf = 1'b1;
        continue;
      end
      t = term_size(a[axis], s, tbl_mass[j], tbl_mass[0], ovf);
      if (d[axis] < 0) acc -= $signed({15'd0, t});
      else acc += $signed({15'd0, t});
    end
    if (acc > ACC_MAX) begin
      acc = ACC_MAX;
      ovf = 1'b1;
    end
    if (acc < ACC_MIN) begin
      acc = ACC_MIN;
      ovf = 1'b1;
    end
    res.acceleration = acc[47:0];
    res.overflow = ovf;
    return res;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        n_items++;
        if (item_ch.kind == KIND_LOAD) begin
          tbl_mass[item_ch.body_index] = item_ch.mass;
          tbl_x[item_ch.body_index] = item_ch.pos_x;
          tbl_y[item_ch.body_index] = item_ch.pos_y;
          tbl_z[item_ch.body_index] = item_ch.pos_z;
          n_loads++;
        end else begin
          expected_accels.push_back(predict_accel(item_ch.body_index, item_ch.axis));
          n_queries++;
        end
      end
      if (!item_ch.valid || item_ch.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          item_ch.valid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          beat_t b;
          b = pending_beats.pop_front();
          item_ch.valid <= 1'b1;
          item_ch.kind <= b.kind;
          item_ch.body_index <= b.body_index;
          item_ch.axis <= b.axis;
          item_ch.mass <= b.mass;
          item_ch.pos_x <= b.pos_x;
          item_ch.pos_y <= b.pos_y;
          item_ch.pos_z <= b.pos_z;
          send_gap <= pick_gap();
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      stall_len <= 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_accels.size() == 0) begin
          $error("result beat with no query outstanding");
          fails++;
        end else begin
          accel_t e;
          e = expected_accels.pop_front();
          n_checked++;
          if (e.overflow) n_ovf++;
          if (res_ch.acceleration !== e.acceleration) begin
            $error("acceleration: expected %0d, got %0d",
                   $signed(e.acceleration), $signed(res_ch.acceleration));
            fails++;
          end
          if (res_ch.overflow !== e.overflow) begin
            $error("overflow: expected %0b, got %0b", e.overflow, res_ch.overflow);
            fails++;
          end
        end
      end
      if (stall_len > 0) begin
        stall_len <= stall_len - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
        stall_len <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [47:0] offset(int scale);
    logic signed [63:0] v;
    v = $signed({$urandom, $urandom});
    return 48'(v >>> (63 - scale));
  endfunction

  function automatic logic [47:0] rand48();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[47:0];
  endfunction

  task automatic push_load(int idx, logic [47:0] m, logic [47:0] x, logic [47:0] y,
                           logic [47:0] z);
    beat_t b;
    b = '{KIND_LOAD, 4'(idx), 2'($urandom_range(0, 3)), m, x, y, z};
    pending_beats.push_back(b);
  endtask

  task automatic push_query(int idx, logic [1:0] axis);
    beat_t b;
    b = '{KIND_QUERY, 4'(idx), axis, rand48(), rand48(), rand48(), rand48()};
    pending_beats.push_back(b);
  endtask

  // body near the origin cluster (or anywhere, or on body 0), random distance scale and mass
  task automatic push_cluster_body(int idx);
    int sc, p;
    logic [47:0] m;
    sc = $urandom_range(18, 40);
    p = $urandom_range(0, 99);
    if (p < 5) m = '0;
    else if (p < 10) m = '1;
    else m = rand48() >> $urandom_range(0, 47);
    if (p >= 95)
      push_load(idx, m, rand48(), rand48(), rand48());
    else if (p >= 90 && idx != 0)
      push_load(idx, m, tbl_x[0], tbl_y[0], tbl_z[0]);
    else
      push_load(idx, m, offset(sc), offset(sc), offset(sc));
  endtask

  // sampled on the falling edge so that the driver's updates have settled
  task automatic drain();
    while (pending_beats.size() != 0 || item_ch.valid || expected_accels.size() != 0)
      @(negedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_count(logic [4:0] v);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    active_count = v;
    n_settings++;
  endtask

  initial begin
    int bc, p, nq;
    item_ch.valid = 1'b0;
    item_ch.kind = KIND_LOAD;
    item_ch.body_index = '0;
    item_ch.axis = AXIS_X;
    item_ch.mass = '0;
    item_ch.pos_x = '0;
    item_ch.pos_y = '0;
    item_ch.pos_z = '0;
    res_ch.ready = 1'b0;
    cfg_write = 1'b0;
    cfg_data = '0;
    active_count = BODY_COUNT_RST;
    for (int i = 0; i < NBODIES; i++) begin
      tbl_mass[i] = '0;
      tbl_x[i] = '0;
      tbl_y[i] = '0;
      tbl_z[i] = '0;
    end
    rst = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: whole table, extremes on the upper bodies
    no_idle = 1'b1;
    push_load(0, 48'd1 << 30, '0, '0, '0);
    for (int i = 1; i < 13; i++) push_cluster_body(i);
    push_load(13, '1, 48'h7fff_ffff_ffff, 48'h8000_0000_0000, 48'h0000_0000_0001);
    push_load(14, '1, 48'h8000_0000_0000, 48'h7fff_ffff_ffff, 48'hffff_ffff_ffff);
    push_load(15, 48'd1, 48'h0000_0001_0000, 48'h0000_0000_0000, 48'h7fff_ffff_ffff);
    push_query(1, AXIS_X);
    push_query(2, AXIS_Y);
    push_query(3, AXIS_Z);
    push_query(4, AXIS_NONE);
    push_query(13, AXIS_X);
    drain();
    set_count(5'd16);
    push_query(15, AXIS_Z);
    push_query(0, AXIS_X);
    drain();
    set_count(5'd31);
    push_query(14, AXIS_Y);
    drain();
    set_count(5'd0);
    push_query(0, AXIS_X);
    drain();
    set_count(5'd1);
    push_query(0, AXIS_Y);
    drain();
    // coincident bodies, then zero mass of body 0
    set_count(5'd3);
    push_load(2, 48'd5000, tbl_x[1], tbl_y[1], tbl_z[1]);
    push_query(1, AXIS_X);
    push_load(0, '0, '0, '0, '0);
    push_query(2, AXIS_Z);
    drain();

    // random phases
    no_idle = 1'b0;
    while (n_items < 290) begin
      p = $urandom_range(0, 99);
      if (p < 70) bc = $urandom_range(2, 5);
      else if (p < 85) bc = $urandom_range(6, 16);
      else bc = $urandom_range(0, 31);
      set_count(5'(bc));
      no_idle = $urandom_range(0, 4) == 0;
      nq = $urandom_range(3, 8);
      for (int k = 0; k < nq; k++) begin
        if ($urandom_range(0, 99) < 55)
          push_cluster_body($urandom_range(0, bc > 1 && bc <= 16 ? bc - 1 : 15));
        else
          push_query($urandom_range(0, bc > 1 && bc <= 16 ? bc - 1 : 15),
                     2'($urandom_range(0, 3)));
      end
      drain();
    end

    $display("tb: %0d loads and %0d queries over %0d body-count settings",
             n_loads, n_queries, n_settings);
    $display("tb: %0d results compared, %0d of them flagged overflow", n_checked, n_ovf);
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
